>>> rtl/dual_axis_texture_shift_wave_macros.svh
// Assertion macros for the texture shift wave block.
// Used by the port checker; no other dependencies.
`ifndef DUAL_AXIS_TEXTURE_SHIFT_WAVE_MACROS_SVH
`define DUAL_AXIS_TEXTURE_SHIFT_WAVE_MACROS_SVH
// implication checked while out of reset
`define DATSW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked while out of reset
`define DATSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/datsw_pkg.sv
// Package for the texture shift wave block: style codes, register indexes,
// widths and the sine table function. No dependencies.
package datsw_pkg;
  localparam int TimeW = 32;
  localparam int PerW = 16;
  localparam int AmpW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam logic [63:0] TurnPerRad = 64'd683565276;

  typedef enum logic [1:0] {
    STYLE_SAW = 2'd0, STYLE_SIN = 2'd1, STYLE_COS = 2'd2, STYLE_SNAP = 2'd3
  } style_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_U_STYLE = 3'd0, REG_U_PER = 3'd1, REG_U_AMP = 3'd2,
    REG_V_STYLE = 3'd3, REG_V_PER = 3'd4, REG_V_AMP = 3'd5
  } reg_idx_t;

  typedef struct packed {
    style_t            style;
    logic [PerW-1:0]   period;
    logic signed [AmpW-1:0] amp;
  } axis_cfg_t;

  function automatic logic signed [63:0] mq30(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p / 64'sd1073741824;
  endfunction

  // Quarter-wave sine sample, Q1.15, from a constant angle x in Q30.
  function automatic logic [16:0] sine_entry(input logic signed [63:0] x);
    logic signed [63:0] x2, b, s;
    x2 = mq30(x, x);
    b = 64'sd1073741824 - mq30(x2, 64'sd1073741824) / 156;
    b = 64'sd1073741824 - mq30(x2, b) / 110;
    b = 64'sd1073741824 - mq30(x2, b) / 72;
    b = 64'sd1073741824 - mq30(x2, b) / 42;
    b = 64'sd1073741824 - mq30(x2, b) / 20;
    b = 64'sd1073741824 - mq30(x2, b) / 6;
    s = mq30(x, b);
    if (s < 0) s = 0;
    s = (s + 64'sd16384) / 64'sd32768;
    if (s > 64'sd32768) s = 64'sd32768;
    return s[16:0];
  endfunction
endpackage

>>> rtl/datsw_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface datsw_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/datsw_div_cell.sv
// One restoring-division cell: one quotient bit per cycle along the chain while en is high.
// Depends on nothing.
module datsw_div_cell #(
  parameter int NW = 48,
  parameter int DW = 16,
  parameter int BIT = 0,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW:0]   rem_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic [DW:0]   rem_o,
  output logic [NW-1:0] num_o,
  output logic [DW-1:0] den_o,
  output logic [TW-1:0] tag_o
);
  logic [DW+1:0] sh;
  logic [DW+1:0] df;
  logic [DW:0]   rem_nxt;
  logic [NW-1:0] num_nxt;

  always_comb begin
    sh = {rem_i, num_i[BIT]};
    df = sh - {2'b00, den_i};
    num_nxt = num_i;
    if (!df[DW+1]) begin
      rem_nxt = df[DW:0];
      num_nxt[BIT] = 1'b1;
    end else begin
      rem_nxt = sh[DW:0];
      num_nxt[BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= rem_nxt;
      num_o <= num_nxt;
      den_o <= den_i;
      tag_o <= tag_i;
    end
  end
endmodule

>>> rtl/datsw_axis.sv
// One axis: chain of division cells, phase multiply, table read, scaling.
// Depends on datsw_pkg and datsw_div_cell.
module datsw_axis #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          time_ms,
  input  datsw_pkg::axis_cfg_t cfg,
  output logic signed [15:0]   shift
);
  localparam int NW = 32 + PHASE_FRAC_BITS;
  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int FW = AW + 2;
  localparam int TW = 2 + 16;
  localparam int PW = PHASE_FRAC_BITS + 32;

  logic [16:0]  rem_c [NW+1];
  logic [NW-1:0] num_c [NW+1];
  logic [15:0]  den_c [NW+1];
  logic [TW-1:0] tag_c [NW+1];
  logic [15:0]  per;

  assign per = (cfg.period == '0) ? 16'd1 : cfg.period;
  assign rem_c[0] = '0;
  assign num_c[0] = {time_ms, {PHASE_FRAC_BITS{1'b0}}};
  assign den_c[0] = per;
  assign tag_c[0] = {cfg.style, cfg.amp};

  for (genvar g = 0; g < NW; g++) begin : g_cell
    datsw_div_cell #(.NW(NW), .DW(16), .BIT(NW-1-g), .TW(TW)) u_cell (
      .clk, .en,
      .rem_i(rem_c[g]), .num_i(num_c[g]), .den_i(den_c[g]), .tag_i(tag_c[g]),
      .rem_o(rem_c[g+1]), .num_o(num_c[g+1]), .den_o(den_c[g+1]),
      .tag_o(tag_c[g+1])
    );
  end

  // After the 32 cells that consume the bits of t the remainder is t mod P;
  // delay it along the rest of the chain so it lines up with the quotient.
  logic [15:0] r32_c [NW-31];
  assign r32_c[0] = rem_c[32][15:0];
  for (genvar g = 0; g < NW - 32; g++) begin : g_rdly
    always_ff @(posedge clk) if (en) r32_c[g+1] <= r32_c[g];
  end

  // stage A: phase products
  logic [63:0] lo_r, hi_r;
  logic [15:0] r_a_r, per_a_r;
  logic [TW-1:0] tag_a_r;
  logic [NW-1:0] q;
  logic [63:0] ql, qh;
  assign q = num_c[NW];
  assign ql = {32'd0, q[31:0]};
  assign qh = 64'(q >> 32);
  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= ql * datsw_pkg::TurnPerRad;
      hi_r <= qh * datsw_pkg::TurnPerRad;
      r_a_r <= r32_c[NW-32];
      per_a_r <= den_c[NW];
      tag_a_r <= tag_c[NW];
    end
  end

  // stage B: table index and snap/saw products
  logic [63:0] pf;
  logic [FW-1:0] idx, idxc;
  logic [16:0] tbl [SINE_TABLE_DEPTH+1];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tbl
    localparam logic signed [63:0] Ang = (64'sd1686629713 * g) / SINE_TABLE_DEPTH;
    localparam logic [16:0] Ent = datsw_pkg::sine_entry(Ang);
    assign tbl[g] = Ent;
  end
  always_comb begin
    pf = lo_r + ((hi_r & ((64'd1 << PHASE_FRAC_BITS) - 64'd1)) << 32);
    idx = pf[PW-1 -: FW];
    idxc = idx + FW'(SINE_TABLE_DEPTH);
  end
  logic [FW-1:0] ix;
  logic [AW-1:0] jj;
  logic [AW:0]   ta;
  assign ix = (datsw_pkg::style_t'(tag_a_r[TW-1 -: 2]) == datsw_pkg::STYLE_COS) ? idxc : idx;
  assign jj = ix[AW-1:0];
  assign ta = ix[AW] ? ((AW+1)'(SINE_TABLE_DEPTH) - {1'b0, jj}) : {1'b0, jj};

  logic signed [17:0] sn_b_r;
  logic signed [33:0] ra_b_r;
  logic signed [33:0] ap_b_r;
  logic signed [15:0] amp_b_r;
  datsw_pkg::style_t  sty_b_r;
  logic signed [15:0] amp_a;
  assign amp_a = tag_a_r[15:0];
  always_ff @(posedge clk) begin
    if (en) begin
      sn_b_r <= ix[AW+1] ? -$signed({1'b0, tbl[ta]}) : $signed({1'b0, tbl[ta]});
      ra_b_r <= $signed({1'b0, r_a_r}) * amp_a;
      ap_b_r <= $signed({1'b0, per_a_r}) * amp_a;
      amp_b_r <= amp_a;
      sty_b_r <= datsw_pkg::style_t'(tag_a_r[TW-1 -: 2]);
    end
  end

  // stage C: snap levels by exact compares of 4*r*A against k*A*P.
  logic signed [35:0] snp;
  logic signed [15:0] snap_v;
  always_comb begin
    snp = 36'(ra_b_r) <<< 2;
    if (snp < 36'(ap_b_r)) snap_v = '0;
    else if (snp < 36'(ap_b_r) * 2) snap_v = 16'(amp_b_r / 16'sd4);
    else if (snp < 36'(ap_b_r) * 3) snap_v = 16'((17'(amp_b_r) * 2) / 17'sd4);
    else snap_v = 16'((18'(amp_b_r) * 3) / 18'sd4);
  end

  // saw: |r*A| / P via a second short division chain (33 quotient bits, low 16 used)
  logic [32:0] mag;
  logic        neg;
  assign neg = ra_b_r < 0;
  assign mag = neg ? 33'(-ra_b_r) : 33'(ra_b_r);
  logic [15:0] per_b_r, per_dly;
  always_ff @(posedge clk) if (en) per_b_r <= per_a_r;
  assign per_dly = per_b_r;
  logic [16:0] srem [34];
  logic [32:0] snum [34];
  logic [15:0] sden [34];
  logic [TW-1:0] stag [34];
  assign srem[0] = '0;
  assign snum[0] = mag;
  assign sden[0] = per_dly;
  logic signed [32:0] sinm;
  assign sinm = sn_b_r * amp_b_r;
  logic signed [15:0] trig_v;
  always_comb begin
    logic signed [32:0] d;
    d = sinm / 33'sd32768;
    if (d > 33'sd32767) trig_v = 16'sh7fff;
    else if (d < -33'sd32768) trig_v = 16'sh8000;
    else trig_v = d[15:0];
  end
  assign stag[0] = {neg, (sty_b_r == datsw_pkg::STYLE_SAW) ? 1'b1 : 1'b0,
                    (sty_b_r == datsw_pkg::STYLE_SNAP) ? snap_v : trig_v};
  for (genvar g = 0; g < 33; g++) begin : g_saw
    datsw_div_cell #(.NW(33), .DW(16), .BIT(32-g), .TW(TW)) u_scell (
      .clk, .en,
      .rem_i(srem[g]), .num_i(snum[g]), .den_i(sden[g]), .tag_i(stag[g]),
      .rem_o(srem[g+1]), .num_o(snum[g+1]), .den_o(sden[g+1]),
      .tag_o(stag[g+1])
    );
  end
  logic [32:0] sq;
  assign sq = snum[33];
  always_comb begin
    if (stag[33][16]) shift = stag[33][17] ? -$signed(sq[15:0]) : $signed(sq[15:0]);
    else shift = stag[33][15:0];
  end
endmodule

>>> rtl/dual_axis_texture_shift_wave.sv
// Dual-axis texture shift wave generator, top level.
// The pipe is PHASE_FRAC_BITS+32 division cells, two arithmetic stages and 33
// scaling cells; the last scaling cell drives the outputs. Throughput: one
// request per cycle; the cell chains advance whenever the last cell is
// empty or its result is taken. Reset clears valid flags and sets both axes
// to sawtooth, period 1, amplitude 256. Depends on datsw_pkg and datsw_axis.
module dual_axis_texture_shift_wave #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [31:0] in_time_ms,
  input  logic in_visible,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] out_shift_u,
  output logic signed [15:0] out_shift_v,
  input  logic cfg_we,
  input  logic [datsw_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [datsw_pkg::CfgDataW-1:0] cfg_data
);
  localparam int LAT = PHASE_FRAC_BITS + 32 + 2 + 33;
  datsw_pkg::axis_cfg_t u_cfg_r, v_cfg_r;
  logic [LAT-1:0] vld_r;
  logic en;

  // Advance the whole pipe unless the output holds a result nobody takes.
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_cfg_r <= '{datsw_pkg::STYLE_SAW, 16'd1, 16'sd256};
      v_cfg_r <= '{datsw_pkg::STYLE_SAW, 16'd1, 16'sd256};
    end else if (cfg_we) begin
      case (datsw_pkg::reg_idx_t'(cfg_index))
        datsw_pkg::REG_U_STYLE: u_cfg_r.style <= datsw_pkg::style_t'(cfg_data[1:0]);
        datsw_pkg::REG_U_PER:   u_cfg_r.period <= cfg_data;
        datsw_pkg::REG_U_AMP:   u_cfg_r.amp <= cfg_data;
        datsw_pkg::REG_V_STYLE: v_cfg_r.style <= datsw_pkg::style_t'(cfg_data[1:0]);
        datsw_pkg::REG_V_PER:   v_cfg_r.period <= cfg_data;
        datsw_pkg::REG_V_AMP:   v_cfg_r.amp <= cfg_data;
        default: ;
      endcase
    end
  end

  // Track which pipe slots carry a visible request; drop invisible ones.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid && in_visible};
  end
  assign out_valid = vld_r[LAT-1];

  datsw_axis #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .PHASE_FRAC_BITS(PHASE_FRAC_BITS))
    u_axis_u (.clk, .en, .time_ms(in_time_ms), .cfg(u_cfg_r), .shift(out_shift_u));
  datsw_axis #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .PHASE_FRAC_BITS(PHASE_FRAC_BITS))
    u_axis_v (.clk, .en, .time_ms(in_time_ms), .cfg(v_cfg_r), .shift(out_shift_v));
endmodule

>>> rtl/datsw_checker.sv
// Port checker for the texture shift wave block, bound to the top level.
// Depends on dual_axis_texture_shift_wave_macros.svh.
`include "dual_axis_texture_shift_wave_macros.svh"
module datsw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [15:0] out_shift_u
);
  `DATSW_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_shift_u))
  `DATSW_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready)
  `DATSW_ASSERT_IMP(a_stall, clk, rst_n, out_valid && !out_ready, !in_ready)
endmodule

bind dual_axis_texture_shift_wave datsw_checker u_chk (.*);

>>> bench/datsw_bench_pkg.sv
// Request and result payload types for the texture shift wave testbench.
// Depends on datsw_pkg for the field widths.
package datsw_bench_pkg;
  typedef struct packed {
    logic [datsw_pkg::TimeW-1:0] time_ms;
    logic                        visible;
  } frame_req_t;

  typedef struct packed {
    logic signed [datsw_pkg::AmpW-1:0] shift_u;
    logic signed [datsw_pkg::AmpW-1:0] shift_v;
  } shift_res_t;
endpackage

>>> bench/dual_axis_texture_shift_wave_test.sv
// Testbench for dual_axis_texture_shift_wave: directed and random frames, a shift predictor
// per axis and an in-order result check. Depends on datsw_pkg, datsw_bench_pkg, datsw_if.
module dual_axis_texture_shift_wave_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 1024;
  localparam int PhaseBits = 16;
  localparam int DrainCycles = 200;
  localparam int LongHold = 400;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [datsw_pkg::CfgIdxW-1:0] cfg_index;
  logic [datsw_pkg::CfgDataW-1:0] cfg_data;

  datsw_if #(.payload_t(datsw_bench_pkg::frame_req_t)) req_ch ();
  datsw_if #(.payload_t(datsw_bench_pkg::shift_res_t)) res_ch ();

  dual_axis_texture_shift_wave u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .in_time_ms(req_ch.data.time_ms), .in_visible(req_ch.data.visible),
    .out_valid(res_ch.valid), .out_ready(res_ch.ready),
    .out_shift_u(res_ch.data.shift_u), .out_shift_v(res_ch.data.shift_v),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the axis registers and the quarter-wave table.
  datsw_pkg::axis_cfg_t u_cfg, v_cfg;
  logic [16:0] quarter_sine [0:Depth];
  datsw_bench_pkg::shift_res_t pending_shifts [$];
  int unsigned error_count;
  bit sender_gaps, receiver_stalls, hold_receiver;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Taylor sine in Q30, rounded to Q15.
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / 64'sd1073741824;
  endfunction

  task automatic build_quarter_sine();
    longint x, x2, acc, s;
    for (int i = 0; i <= Depth; i++) begin
      x = (64'sd1686629713 * i) / Depth;
      x2 = q30_mul(x, x);
      acc = 64'sd1073741824 - q30_mul(x2, 64'sd1073741824) / 156;
      acc = 64'sd1073741824 - q30_mul(x2, acc) / 110;
      acc = 64'sd1073741824 - q30_mul(x2, acc) / 72;
      acc = 64'sd1073741824 - q30_mul(x2, acc) / 42;
      acc = 64'sd1073741824 - q30_mul(x2, acc) / 20;
      acc = 64'sd1073741824 - q30_mul(x2, acc) / 6;
      s = q30_mul(x, acc);
      if (s < 0) s = 0;
      s = (s + 16384) / 32768;
      if (s > 32768) s = 32768;
      quarter_sine[i] = s[16:0];
    end
  endtask

  function automatic longint wave_sample(logic [31:0] t, longint unsigned p, bit cosine);
    longint unsigned q, qh, ql, lo, hi, frac, h, idx, quad, j;
    q = ({32'd0, t} << PhaseBits) / p;
    qh = q >> 32;
    ql = q & 64'hFFFF_FFFF;
    lo = ql * 64'd683565276;
    hi = ((qh * 64'd683565276) & ((64'd1 << PhaseBits) - 1)) << 32;
    frac = (lo + hi) & ((64'd1 << (PhaseBits + 32)) - 1);
    h = frac >> (PhaseBits + 32 - 24);
    idx = (h * (4 * Depth)) >> 24;
    if (cosine) idx = (idx + Depth) % (4 * Depth);
    quad = idx / Depth;
    j = idx % Depth;
    case (quad[1:0])
      2'd0: return longint'(quarter_sine[j]);
      2'd1: return longint'(quarter_sine[Depth - j]);
      2'd2: return -longint'(quarter_sine[j]);
      default: return -longint'(quarter_sine[Depth - j]);
    endcase
  endfunction

  function automatic logic signed [15:0] clamp_q88(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] predict_axis_shift(logic [31:0] t,
                                                           datsw_pkg::axis_cfg_t c);
    longint unsigned p;
    longint a, r, scaled;
    p = (c.period == 0) ? 1 : c.period;
    a = longint'(c.amp);
    r = longint'({32'd0, t} % p);
    case (c.style)
      datsw_pkg::STYLE_SAW: return clamp_q88((r * a) / longint'(p));
      datsw_pkg::STYLE_SIN: return clamp_q88((wave_sample(t, p, 1'b0) * a) / 32768);
      datsw_pkg::STYLE_COS: return clamp_q88((wave_sample(t, p, 1'b1) * a) / 32768);
      default: begin
        // Snap to quarter levels; with a negative amplitude the tests mirror.
        scaled = 4 * r * a;
        for (int k = 1; k <= 3; k++)
          if (scaled < k * a * longint'(p))
            return (k == 1) ? 16'sd0 : clamp_q88(((k - 1) * a) / 4);
        return clamp_q88((3 * a) / 4);
      end
    endcase
  endfunction

  // Queue a prediction for every visible request at acceptance.
  always @(posedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready && req_ch.data.visible)
      pending_shifts.push_back('{shift_u: predict_axis_shift(req_ch.data.time_ms, u_cfg),
                                 shift_v: predict_axis_shift(req_ch.data.time_ms, v_cfg)});
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    datsw_bench_pkg::shift_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_shifts.size() == 0) begin
        report_mismatch("unexpected result u", res_ch.data.shift_u, 0);
      end else begin
        want = pending_shifts.pop_front();
        if (res_ch.data.shift_u !== want.shift_u)
          report_mismatch("shift_u", res_ch.data.shift_u, want.shift_u);
        if (res_ch.data.shift_v !== want.shift_v)
          report_mismatch("shift_v", res_ch.data.shift_v, want.shift_v);
      end
    end
  end

  // Receiver: random stall bursts, plus a long counted hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        res_ch.ready <= 1'b0;
        for (int n = 0; n < LongHold; n++) @(posedge clk);
        hold_receiver = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_frame(logic [31:0] t, logic vis);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= '{time_ms: t, visible: vis};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result is in, then let
  // invisible requests still in the pipe drain out.
  task automatic wait_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_shifts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(datsw_pkg::reg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      datsw_pkg::REG_U_STYLE: u_cfg.style = datsw_pkg::style_t'(value[1:0]);
      datsw_pkg::REG_U_PER:   u_cfg.period = value;
      datsw_pkg::REG_U_AMP:   u_cfg.amp = value;
      datsw_pkg::REG_V_STYLE: v_cfg.style = datsw_pkg::style_t'(value[1:0]);
      datsw_pkg::REG_V_PER:   v_cfg.period = value;
      default:                v_cfg.amp = value;
    endcase
    @(posedge clk);
  endtask

  task automatic set_axes(datsw_pkg::style_t us, logic [15:0] up, logic [15:0] ua,
                          datsw_pkg::style_t vs, logic [15:0] vp, logic [15:0] va);
    write_reg(datsw_pkg::REG_U_STYLE, 16'(us));
    write_reg(datsw_pkg::REG_U_PER, up);
    write_reg(datsw_pkg::REG_U_AMP, ua);
    write_reg(datsw_pkg::REG_V_STYLE, 16'(vs));
    write_reg(datsw_pkg::REG_V_PER, vp);
    write_reg(datsw_pkg::REG_V_AMP, va);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_period();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 16));
      1: return 16'($urandom_range(1, 2000));
      2: return 16'($urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [31:0] random_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 100000);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int frames);
    set_axes(datsw_pkg::style_t'($urandom_range(0, 3)), random_period(), 16'($urandom),
             datsw_pkg::style_t'($urandom_range(0, 3)), random_period(), 16'($urandom));
    for (int n = 0; n < frames; n++)
      send_frame(random_time(), $urandom_range(0, 7) != 0);
    wait_quiet();
  endtask

  // Reset values: sawtooth with period one gives zero shift on both axes.
  task automatic test_reset_defaults();
    send_frame(32'd0, 1'b1);
    send_frame(32'd12345, 1'b1);
    wait_quiet();
  endtask

  // Every style across the two axes, extreme amplitudes, periods and times,
  // a zero period and invisible frames.
  task automatic test_directed_extremes();
    logic [31:0] times [5] = '{32'd0, 32'd1, 32'd999, 32'h8000_0000, 32'hFFFF_FFFF};
    set_axes(datsw_pkg::STYLE_SIN, 16'd1, 16'h7FFF, datsw_pkg::STYLE_COS, 16'hFFFF, 16'h8000);
    foreach (times[i]) send_frame(times[i], 1'b1);
    send_frame(32'd77, 1'b0);
    wait_quiet();
    set_axes(datsw_pkg::STYLE_SNAP, 16'd4, 16'h8000, datsw_pkg::STYLE_SAW, 16'hFFFF, 16'h7FFF);
    for (int i = 0; i < 5; i++) send_frame(32'(i), 1'b1);
    send_frame(32'hFFFF_FFFF, 1'b1);
    wait_quiet();
    set_axes(datsw_pkg::STYLE_SAW, 16'd0, 16'h0000, datsw_pkg::STYLE_SNAP, 16'd7, 16'h7FFF);
    for (int i = 0; i < 7; i++) send_frame(32'(i), i != 3);
    wait_quiet();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) random_phase(120);
  endtask

  // Hold the receiver off long enough that the block fills and stalls input.
  task automatic test_backpressure();
    set_axes(datsw_pkg::STYLE_SIN, 16'($urandom_range(1, 500)), 16'($urandom),
             datsw_pkg::STYLE_SNAP, 16'($urandom_range(1, 50)), 16'($urandom));
    hold_receiver = 1'b1;
    for (int n = 0; n < 250; n++) send_frame(random_time(), 1'b1);
    wait_quiet();
  endtask

  // Last part: no idling on either side.
  task automatic test_full_rate();
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    random_phase(150);
    random_phase(150);
  endtask

  initial begin
    rst_n <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    error_count = 0;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    hold_receiver = 1'b0;
    u_cfg = '{style: datsw_pkg::STYLE_SAW, period: 16'd1, amp: 16'sd256};
    v_cfg = '{style: datsw_pkg::STYLE_SAW, period: 16'd1, amp: 16'sd256};
    build_quarter_sine();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed_extremes();
    test_random_settings();
    test_backpressure();
    test_full_rate();

    if (pending_shifts.size() != 0)
      report_mismatch("results outstanding", pending_shifts.size(), 0);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
